// File: rtl/core/prls_pkg.sv
// Shared types and constants of the priority ready-list scheduler.
package prls_pkg;

    localparam int unsigned ID_W   = 4;
    localparam int unsigned PRIO_W = 8;
    localparam int unsigned MSG_W  = 32;
    localparam int unsigned QNT_W  = 8;
    localparam int unsigned ST_W   = 4;

    localparam logic [ST_W-1:0] READY_STATE = 4'd1;

    typedef enum logic [2:0] {
        OP_MAKE_READY = 3'd0,
        OP_SLEEP      = 3'd1,
        OP_WAKEUP     = 3'd2,
        OP_RESCHED    = 3'd3,
        OP_FORCE      = 3'd4,
        OP_TICK       = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_FULL  = 2'd1,
        ERR_EMPTY = 2'd2,
        ERR_PRIO  = 2'd3
    } t_err;

    localparam logic [1:0] CFG_QUANTUM = 2'd0;
    localparam logic [1:0] CFG_OK_MSG  = 2'd1;
    localparam logic [1:0] CFG_INIT_PR = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;   // latch the input item and compute the decision
        logic apply;     // perform the list updates and form the result
    } t_cmd;

endpackage

// File: rtl/core/priority_ready_list_scheduler.sv
// Top level of the priority ready-list scheduler.
// Each operation has a capture step, which latches the item and decides, and an apply
// step, which updates the sorted shift-register list, running thread and message store;
// the result then sits in an output register, and the next item is taken in the cycle
// that result leaves. The ready list keeps higher priorities first and FIFO order
// among equals; errors leave the ready list, running thread, quantum counter and
// messages alone. Configuration writes land immediately; quantum and initial priority
// also load the live counters until the first operation is taken.
module priority_ready_list_scheduler
    import prls_pkg::*;
#(
    parameter int unsigned MAX_THREADS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [1:0]              i_cfg_idx,
    input  logic [31:0]             i_cfg_data,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [2:0]              i_operation,
    input  logic [3:0]              i_thread_id,
    input  logic [7:0]              i_thread_priority,
    input  logic signed [31:0]      i_message,
    input  logic [3:0]              i_sleep_state,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic                    o_switched,
    output logic [3:0]              o_from_thread,
    output logic [3:0]              o_to_thread,
    output logic [3:0]              o_from_state,
    output logic signed [31:0]      o_resumed_message,
    output logic                    o_resched_required,
    output logic [1:0]              o_error
);

    t_cmd w_cmd;

    prls_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .o_valid, .i_ready, .o_cmd(w_cmd)
    );

    prls_dp #(.MAX_THREADS(MAX_THREADS)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_operation, .i_thread_id, .i_thread_priority, .i_message, .i_sleep_state,
        .o_switched, .o_from_thread, .o_to_thread, .o_from_state,
        .o_resumed_message, .o_resched_required, .o_error
    );

endmodule

// File: rtl/core/prls_ctrl.sv
// Controller state machine of the priority ready-list scheduler.
module prls_ctrl
    import prls_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    output logic o_valid,
    input  logic i_ready,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_APPLY = 3'b010,
        S_OUT   = 3'b100
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_valid) n_state = S_APPLY;
            S_APPLY: n_state = S_OUT;
            S_OUT:   if (i_ready) n_state = i_valid ? S_APPLY : S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // A new item is taken as soon as the previous result leaves.
    assign o_ready       = (r_state == S_IDLE) || (r_state == S_OUT && i_ready);
    assign o_valid       = (r_state == S_OUT);
    assign o_cmd.capture = o_ready && i_valid;
    assign o_cmd.apply   = (r_state == S_APPLY);

`ifndef SYNTHESIS
    a_apply_after_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> o_cmd.apply) else $error("apply did not follow capture");
    a_out_after_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.apply |=> o_valid) else $error("result not shown after apply");
    a_no_capture_in_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.apply |-> !o_ready) else $error("item taken during apply");
`endif

endmodule

// File: rtl/core/prls_dp.sv
// Datapath of the priority ready-list scheduler: sorted list, running thread, messages.
module prls_dp
    import prls_pkg::*;
#(
    parameter int unsigned MAX_THREADS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    input  logic                    i_cfg_we,
    input  logic [1:0]              i_cfg_idx,
    input  logic [MSG_W-1:0]        i_cfg_data,
    input  logic [2:0]              i_operation,
    input  logic [ID_W-1:0]         i_thread_id,
    input  logic [PRIO_W-1:0]       i_thread_priority,
    input  logic signed [MSG_W-1:0] i_message,
    input  logic [ST_W-1:0]         i_sleep_state,
    output logic                    o_switched,
    output logic [ID_W-1:0]         o_from_thread,
    output logic [ID_W-1:0]         o_to_thread,
    output logic [ST_W-1:0]         o_from_state,
    output logic signed [MSG_W-1:0] o_resumed_message,
    output logic                    o_resched_required,
    output logic [1:0]              o_error
);

    localparam int unsigned CNT_W = $clog2(MAX_THREADS + 1);
    localparam int unsigned NSLOT = 1 << ID_W;

    // Configuration.
    logic [QNT_W-1:0]  r_quantum;
    logic [MSG_W-1:0]  r_ok_msg;
    logic              r_started;

    // Scheduler state.
    logic [ID_W-1:0]   r_ids   [MAX_THREADS];
    logic [PRIO_W-1:0] r_prios [MAX_THREADS];
    logic [CNT_W-1:0]  r_count;
    logic [ID_W-1:0]   r_run_id;
    logic [PRIO_W-1:0] r_run_prio;
    logic [QNT_W-1:0]  r_qleft;
    logic [MSG_W-1:0]  r_msgs [NSLOT];

    // Captured decision.
    logic              r_do_pop;     // remove head
    logic              r_do_ins;     // insert r_ins_id / r_ins_prio
    logic [ID_W-1:0]   r_ins_id;
    logic [PRIO_W-1:0] r_ins_prio;
    logic              r_new_run;    // running thread changes
    logic [ID_W-1:0]   r_nrun_id;
    logic [PRIO_W-1:0] r_nrun_prio;
    logic              r_wr_msg;
    logic [ID_W-1:0]   r_wr_id;
    logic [MSG_W-1:0]  r_wr_data;
    logic              r_reload;
    logic              r_tick;
    logic [ST_W-1:0]   r_fstate;
    logic [1:0]        r_err;

    // Result registers.
    logic              r_switched;
    logic [ID_W-1:0]   r_from;
    logic [ST_W-1:0]   r_out_state;
    logic              r_req;
    logic [1:0]        r_out_err;
    logic [MSG_W-1:0]  r_rmsg;

    // Decision from the current state and the incoming item.
    logic              c_full, c_empty, c_head_gt, c_head_ge, c_pz;
    logic              d_pop, d_ins, d_run, d_wr, d_rel, d_tick;
    logic [ID_W-1:0]   d_ins_id, d_nrun_id, d_wr_id;
    logic [PRIO_W-1:0] d_ins_prio, d_nrun_prio;
    logic [MSG_W-1:0]  d_wr_data;
    logic [ST_W-1:0]   d_fstate;
    logic [1:0]        d_err;
    t_op               c_op;

    always_comb begin
        c_op      = t_op'(i_operation);
        c_full    = (r_count >= CNT_W'(MAX_THREADS));
        c_empty   = (r_count == '0);
        c_head_gt = !c_empty && (r_prios[0] > r_run_prio);
        c_head_ge = !c_empty && (r_prios[0] >= r_run_prio);
        c_pz      = (i_thread_priority == '0);
        d_pop = 1'b0; d_ins = 1'b0; d_run = 1'b0; d_wr = 1'b0;
        d_rel = 1'b0; d_tick = 1'b0;
        d_ins_id = i_thread_id; d_ins_prio = i_thread_priority;
        d_nrun_id = r_ids[0]; d_nrun_prio = r_prios[0];
        d_wr_id = i_thread_id; d_wr_data = i_message;
        d_fstate = '0; d_err = ERR_NONE;
        case (c_op)
            OP_MAKE_READY: begin
                if (c_pz) d_err = ERR_PRIO;
                else if (c_full) d_err = ERR_FULL;
                else begin
                    d_wr = 1'b1; d_ins = 1'b1;
                end
            end
            OP_SLEEP: begin
                if (c_empty) d_err = ERR_EMPTY;
                else begin
                    d_pop = 1'b1; d_run = 1'b1; d_rel = 1'b1; d_fstate = i_sleep_state;
                end
            end
            OP_WAKEUP: begin
                if (c_pz) d_err = ERR_PRIO;
                else if (c_full) d_err = ERR_FULL;
                else if (i_thread_priority <= r_run_prio) begin
                    d_wr = 1'b1; d_ins = 1'b1;
                end else begin
                    // The woken thread preempts; the runner is requeued. The
                    // runner's ok message is overwritten by the woken one's
                    // only when the ids coincide, which d_wr below handles.
                    d_ins = 1'b1; d_ins_id = r_run_id; d_ins_prio = r_run_prio;
                    d_run = 1'b1; d_nrun_id = i_thread_id;
                    d_nrun_prio = i_thread_priority;
                    d_wr = 1'b1; d_rel = 1'b1; d_fstate = READY_STATE;
                end
            end
            OP_RESCHED, OP_FORCE: begin
                if ((c_op == OP_RESCHED) ? c_head_gt : c_head_ge) begin
                    d_pop = 1'b1; d_ins = 1'b1; d_ins_id = r_run_id;
                    d_ins_prio = r_run_prio; d_run = 1'b1;
                    d_wr = 1'b1; d_wr_id = r_run_id; d_wr_data = r_ok_msg;
                    d_rel = 1'b1; d_fstate = READY_STATE;
                end else if (c_op == OP_FORCE) begin
                    d_wr = 1'b1; d_wr_id = r_run_id; d_wr_data = r_ok_msg;
                    d_rel = 1'b1;
                end
            end
            OP_TICK: d_tick = 1'b1;
            default: ;
        endcase
    end

    // Second message write for a preempting wakeup: ok message to the old runner.
    logic r_wr2;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_do_pop <= d_pop; r_do_ins <= d_ins;
            r_ins_id <= d_ins_id; r_ins_prio <= d_ins_prio;
            r_new_run <= d_run; r_nrun_id <= d_nrun_id; r_nrun_prio <= d_nrun_prio;
            r_wr_msg <= d_wr; r_wr_id <= d_wr_id; r_wr_data <= d_wr_data;
            r_reload <= d_rel; r_tick <= d_tick; r_fstate <= d_fstate;
            r_err <= d_err; r_from <= r_run_id;
            r_wr2 <= (c_op == OP_WAKEUP) && d_run;
        end
    end

    // Sorted list update: pop shifts up, insert shifts down behind all >= prio.
    logic [ID_W-1:0]   n_ids   [MAX_THREADS];
    logic [PRIO_W-1:0] n_prios [MAX_THREADS];
    logic [ID_W-1:0]   s_ids   [MAX_THREADS];
    logic [PRIO_W-1:0] s_prios [MAX_THREADS];
    logic [MAX_THREADS-1:0] s_ge;
    logic [CNT_W-1:0]  s_cnt;

    always_comb begin
        s_cnt = r_do_pop ? r_count - CNT_W'(1) : r_count;
        for (int i = 0; i < MAX_THREADS; i++) begin
            if (r_do_pop && i + 1 < MAX_THREADS) begin
                s_ids[i]   = r_ids[i + 1];
                s_prios[i] = r_prios[i + 1];
            end else begin
                s_ids[i]   = r_ids[i];
                s_prios[i] = r_prios[i];
            end
        end
        for (int i = 0; i < MAX_THREADS; i++) begin
            s_ge[i] = (CNT_W'(i) < s_cnt) && (s_prios[i] >= r_ins_prio);
        end
        for (int i = 0; i < MAX_THREADS; i++) begin
            n_ids[i] = s_ids[i]; n_prios[i] = s_prios[i];
            if (r_do_ins && !s_ge[i]) begin
                if (i == 0 || s_ge[(i == 0) ? 0 : i - 1]) begin
                    n_ids[i] = r_ins_id; n_prios[i] = r_ins_prio;
                end else begin
                    n_ids[i]   = s_ids[(i == 0) ? 0 : i - 1];
                    n_prios[i] = s_prios[(i == 0) ? 0 : i - 1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.apply) begin
            for (int i = 0; i < MAX_THREADS; i++) begin
                r_ids[i]   <= n_ids[i];
                r_prios[i] <= n_prios[i];
            end
        end
    end

    // Control state with reset.
    logic [CNT_W-1:0]  n_count;
    logic [PRIO_W-1:0] n_run_prio;
    logic [QNT_W-1:0]  n_qleft;
    logic [ID_W-1:0]   n_run_id;

    always_comb begin
        n_count    = s_cnt + (r_do_ins ? CNT_W'(1) : CNT_W'(0));
        n_run_id   = r_new_run ? r_nrun_id : r_run_id;
        n_run_prio = r_new_run ? r_nrun_prio : r_run_prio;
        if (r_reload) n_qleft = r_quantum;
        else if (r_tick && r_qleft != '0) n_qleft = r_qleft - QNT_W'(1);
        else n_qleft = r_qleft;
    end

    // Thread messages: written in the apply cycle. The message of the thread
    // running afterwards is read in the same cycle, taking this cycle's writes
    // into account, and held for the result.
    always_ff @(posedge i_clk) begin
        if (i_cmd.apply) begin
            if (r_wr2 && (r_ins_id != r_wr_id)) r_msgs[r_ins_id] <= r_ok_msg;
            if (r_wr_msg) r_msgs[r_wr_id] <= r_wr_data;
            if (r_wr_msg && (r_wr_id == n_run_id)) r_rmsg <= r_wr_data;
            else if (r_wr2 && (r_ins_id == n_run_id)) r_rmsg <= r_ok_msg;
            else r_rmsg <= r_msgs[n_run_id];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quantum <= QNT_W'(20); r_ok_msg <= '0;
            r_started <= 1'b0; r_count <= '0; r_run_id <= '0;
            r_run_prio <= PRIO_W'(64); r_qleft <= QNT_W'(20);
            r_switched <= 1'b0; r_out_state <= '0; r_req <= 1'b0;
            r_out_err <= ERR_NONE;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_QUANTUM: begin
                        r_quantum <= i_cfg_data[QNT_W-1:0];
                        if (!r_started) r_qleft <= i_cfg_data[QNT_W-1:0];
                    end
                    CFG_OK_MSG: r_ok_msg <= i_cfg_data;
                    CFG_INIT_PR: begin
                        if (!r_started) r_run_prio <= i_cfg_data[PRIO_W-1:0];
                    end
                    default: ;
                endcase
            end
            if (i_cmd.capture) r_started <= 1'b1;
            if (i_cmd.apply) begin
                r_count    <= n_count;
                r_run_id   <= n_run_id;
                r_run_prio <= n_run_prio;
                r_qleft    <= n_qleft;
                r_switched <= (n_run_id != r_run_id) || (r_fstate != '0);
                r_out_state <= ((n_run_id != r_run_id) || (r_fstate != '0)) ? r_fstate : '0;
                r_out_err  <= r_err;
                if (n_count == '0) r_req <= 1'b0;
                else if (n_qleft != '0) r_req <= n_prios[0] > n_run_prio;
                else r_req <= n_prios[0] >= n_run_prio;
            end
        end
    end

    assign o_switched         = r_switched;
    assign o_from_thread      = r_from;
    assign o_to_thread        = r_run_id;
    assign o_from_state       = r_out_state;
    assign o_resumed_message  = r_rmsg;
    assign o_resched_required = r_req;
    assign o_error            = r_out_err;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_THREADS)) else $error("ready count overflow");
    a_err_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.apply && r_err != ERR_NONE) |=> $stable(r_count) && $stable(r_run_id))
        else $error("error step changed state");
    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CNT_W'(2)) |-> (r_prios[0] >= r_prios[1]))
        else $error("ready list out of order");
`endif

endmodule
